>>> hw/rtl/lrfd_pkg.sv
`default_nettype none
package lrfd_pkg;

  localparam int FRAME_WIDTH  = 64;
  localparam int FRAME_HEIGHT = 64;
  localparam int PIX_COUNT    = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int ADDR_W       = $clog2(PIX_COUNT);
  localparam int COORD_W      = 6;
  localparam int COLOR_W      = 8;
  localparam int PIX_W        = 3 * COLOR_W;
  localparam int CFG_IDX_W    = 2;

  typedef enum logic [1:0] {
    OP_PLOT = 2'd0,
    OP_LINE = 2'd1,
    OP_RECT = 2'd2,
    OP_READ = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PEN_RED   = 2'd0,
    CFG_PEN_GREEN = 2'd1,
    CFG_PEN_BLUE  = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    SEG_LINE   = 3'd0,
    SEG_TOP    = 3'd1,
    SEG_LEFT   = 3'd2,
    SEG_RIGHT  = 3'd3,
    SEG_BOTTOM = 3'd4
  } seg_t;

  typedef struct packed {
    op_t                op;
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [COORD_W-1:0] end_x;
    logic [COORD_W-1:0] end_y;
  } in_item_t;

  typedef struct packed {
    logic [COLOR_W-1:0] read_red;
    logic [COLOR_W-1:0] read_green;
    logic [COLOR_W-1:0] read_blue;
  } out_item_t;

  typedef struct packed {
    logic clr_step;
    logic load_item;
    logic plot;
    logic seg_load;
    logic seg_step;
    logic rd_issue;
    logic out_load;
    seg_t seg_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic seg_done;
  } dp_stat_t;

endpackage
`default_nettype wire

>>> hw/rtl/lrfd_ctrl.sv
`default_nettype none
module lrfd_ctrl (
  input  wire                logic clk,
  input  wire                logic rst_n,
  input  wire                logic in_valid,
  output logic                     in_ready,
  input  wire  lrfd_pkg::op_t      in_op,
  output logic                     out_valid,
  input  wire                logic out_ready,
  output lrfd_pkg::dp_cmd_t        cmd,
  input  wire  lrfd_pkg::dp_stat_t stat
);
  import lrfd_pkg::*;

  typedef enum logic [6:0] {
    S_CLEAR    = 7'b0000001,
    S_IDLE     = 7'b0000010,
    S_PLOT     = 7'b0000100,
    S_SEG_LOAD = 7'b0001000,
    S_SEG_RUN  = 7'b0010000,
    S_READ     = 7'b0100000,
    S_DONE     = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  seg_t   seg_r, seg_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    seg_nxt       = seg_r;
    cmd           = '0;
    cmd.seg_sel   = seg_r;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r & ~out_ready;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          case (in_op)
            OP_PLOT: state_nxt = S_PLOT;
            OP_LINE: begin
              seg_nxt   = SEG_LINE;
              state_nxt = S_SEG_LOAD;
            end
            OP_RECT: begin
              seg_nxt   = SEG_TOP;
              state_nxt = S_SEG_LOAD;
            end
            default: state_nxt = S_READ;
          endcase
        end
      end
      S_PLOT: begin
        cmd.plot  = 1'b1;
        state_nxt = S_DONE;
      end
      S_SEG_LOAD: begin
        cmd.seg_load = 1'b1;
        state_nxt    = S_SEG_RUN;
      end
      S_SEG_RUN: begin
        if (stat.seg_done) begin
          case (seg_r)
            SEG_TOP: begin
              seg_nxt   = SEG_LEFT;
              state_nxt = S_SEG_LOAD;
            end
            SEG_LEFT: begin
              seg_nxt   = SEG_RIGHT;
              state_nxt = S_SEG_LOAD;
            end
            SEG_RIGHT: begin
              seg_nxt   = SEG_BOTTOM;
              state_nxt = S_SEG_LOAD;
            end
            default: state_nxt = S_DONE;
          endcase
        end else begin
          cmd.seg_step = 1'b1;
        end
      end
      S_READ: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      seg_r       <= SEG_LINE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      seg_r       <= seg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

>>> hw/rtl/lrfd_datapath.sv
`default_nettype none
module lrfd_datapath (
  input  wire                logic clk,
  input  wire                logic rst_n,
  input  wire  lrfd_pkg::dp_cmd_t  cmd,
  output lrfd_pkg::dp_stat_t       stat,
  input  wire  lrfd_pkg::in_item_t in_data,
  output lrfd_pkg::out_item_t      out_data,
  input  wire                logic cfg_we,
  input  wire  lrfd_pkg::cfg_idx_t cfg_index,
  input  wire  [lrfd_pkg::COLOR_W-1:0] cfg_data
);
  import lrfd_pkg::*;

  localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(PIX_COUNT - 1);

  function automatic logic in_frame(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
    in_frame = (32'(x) < FRAME_WIDTH) && (32'(y) < FRAME_HEIGHT);
  endfunction

  function automatic logic [ADDR_W-1:0] pix_addr(input logic [COORD_W-1:0] x,
                                                 input logic [COORD_W-1:0] y);
    pix_addr = ADDR_W'(32'(y) * FRAME_WIDTH + 32'(x));
  endfunction

  logic [PIX_W-1:0]   mem [PIX_COUNT];
  logic [ADDR_W-1:0]  clr_addr_r;
  logic [COLOR_W-1:0] ink_red_r, ink_green_r, ink_blue_r;
  in_item_t           item_r;
  out_item_t          out_r;
  logic [PIX_W-1:0]   rd_data_r;
  logic               rd_ok_r;

  logic [COORD_W-1:0] cur_x_r, cur_y_r, end_x_r, end_y_r, dx_r;
  logic signed [6:0]  dy_r;
  logic signed [7:0]  rem_r;
  logic               vert_r, fin_r;

  logic [COORD_W-1:0] ax, ay, bx, by;
  logic signed [7:0]  dx_s, dy_s;
  logic               rem_ge, rem_neg, seg_plot;
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  logic [PIX_W-1:0]   wr_data, pen_pix;

  always_comb begin
    case (cmd.seg_sel)
      SEG_TOP: begin
        ax = item_r.start_x; ay = item_r.start_y; bx = item_r.end_x;   by = item_r.start_y;
      end
      SEG_LEFT: begin
        ax = item_r.start_x; ay = item_r.start_y; bx = item_r.start_x; by = item_r.end_y;
      end
      SEG_RIGHT: begin
        ax = item_r.end_x;   ay = item_r.start_y; bx = item_r.end_x;   by = item_r.end_y;
      end
      SEG_BOTTOM: begin
        ax = item_r.start_x; ay = item_r.end_y;   bx = item_r.end_x;   by = item_r.end_y;
      end
      default: begin
        ax = item_r.start_x; ay = item_r.start_y; bx = item_r.end_x;   by = item_r.end_y;
      end
    endcase
  end

  assign dx_s     = signed'({2'b00, dx_r});
  assign dy_s     = {dy_r[6], dy_r};
  assign rem_neg  = rem_r[7];
  assign rem_ge   = rem_r >= dx_s;
  assign seg_plot = vert_r || (!rem_neg && !rem_ge);
  assign pen_pix  = {ink_red_r, ink_green_r, ink_blue_r};

  assign stat.clr_done = clr_addr_r == CLR_LAST;
  assign stat.seg_done = vert_r ? (cur_y_r == end_y_r) : fin_r;

  always_ff @(posedge clk) begin
    if (cmd.load_item) item_r <= in_data;
    if (cmd.seg_load) begin
      fin_r <= 1'b0;
      rem_r <= '0;
      if (ax == bx) begin
        vert_r  <= 1'b1;
        cur_x_r <= ax;
        cur_y_r <= (ay < by) ? ay : by;
        end_y_r <= (ay < by) ? by : ay;
      end else if (ax < bx) begin
        vert_r  <= 1'b0;
        cur_x_r <= ax;
        cur_y_r <= ay;
        end_x_r <= bx;
        dx_r    <= bx - ax;
        dy_r    <= signed'({1'b0, by}) - signed'({1'b0, ay});
      end else begin
        vert_r  <= 1'b0;
        cur_x_r <= bx;
        cur_y_r <= by;
        end_x_r <= ax;
        dx_r    <= ax - bx;
        dy_r    <= signed'({1'b0, ay}) - signed'({1'b0, by});
      end
    end else if (cmd.seg_step) begin
      if (vert_r) begin
        cur_y_r <= cur_y_r + 1'b1;
      end else if (rem_ge) begin
        rem_r   <= rem_r - dx_s;
        cur_y_r <= cur_y_r + 1'b1;
      end else if (rem_neg) begin
        rem_r   <= rem_r + dx_s;
        cur_y_r <= cur_y_r - 1'b1;
      end else if (cur_x_r == end_x_r) begin
        fin_r <= 1'b1;
      end else begin
        cur_x_r <= cur_x_r + 1'b1;
        rem_r   <= rem_r + dy_s;
      end
    end
    if (cmd.rd_issue) rd_ok_r <= in_frame(item_r.start_x, item_r.start_y);
    if (cmd.out_load) begin
      out_r <= (item_r.op == OP_READ && rd_ok_r) ? out_item_t'(rd_data_r) : '0;
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = clr_addr_r;
    wr_data = pen_pix;
    if (cmd.clr_step) begin
      wr_en   = 1'b1;
      wr_data = '0;
    end else if (cmd.plot) begin
      wr_en   = in_frame(item_r.start_x, item_r.start_y);
      wr_addr = pix_addr(item_r.start_x, item_r.start_y);
    end else if (cmd.seg_step && seg_plot) begin
      wr_en   = in_frame(cur_x_r, cur_y_r);
      wr_addr = pix_addr(cur_x_r, cur_y_r);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_issue) rd_data_r <= mem[pix_addr(item_r.start_x, item_r.start_y)];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r  <= '0;
      ink_red_r   <= '1;
      ink_green_r <= '1;
      ink_blue_r  <= '1;
    end else begin
      if (cmd.clr_step) clr_addr_r <= clr_addr_r + 1'b1;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_PEN_RED:   ink_red_r   <= cfg_data;
          CFG_PEN_GREEN: ink_green_r <= cfg_data;
          CFG_PEN_BLUE:  ink_blue_r  <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  assign out_data = out_r;

endmodule
`default_nettype wire

>>> hw/rtl/line_rectangle_frame_drawer.sv
// Accept to result: a plot writes in S_PLOT, a read issues in S_READ, a line runs S_SEG_LOAD
// then S_SEG_RUN, a rectangle runs both for each of its four segments; all load the result
// in S_DONE. Throughput: one item at a time; the next item is taken in the cycle after the
// result is loaded, which waits while an earlier result is still held by out_ready. Steps along
// x (or y if vertical) write a pixel; steps that only correct y on sloped lines write nothing.
// Reset: pen color returns to white, then a clearing pass writes black over all 4096 pixels,
// one per cycle, while in_ready stays low; configuration writes are taken throughout.
`default_nettype none
module line_rectangle_frame_drawer (
  input  wire                 logic clk,
  input  wire                 logic rst_n,
  input  wire                 logic in_valid,
  output logic                      in_ready,
  input  wire  lrfd_pkg::in_item_t  in_data,
  output logic                      out_valid,
  input  wire                 logic out_ready,
  output lrfd_pkg::out_item_t       out_data,
  input  wire                 logic cfg_we,
  input  wire  lrfd_pkg::cfg_idx_t  cfg_index,
  input  wire  [lrfd_pkg::COLOR_W-1:0] cfg_data
);
  import lrfd_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  lrfd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_op    (in_data.op),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  lrfd_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .stat     (stat),
    .in_data  (in_data),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

endmodule
`default_nettype wire

>>> dv/tb_line_rectangle_frame_drawer.sv
`timescale 1ns / 1ps
module tb_line_rectangle_frame_drawer;
  import lrfd_pkg::*;

  localparam int RUN_LIMIT     = 2_000_000;
  localparam int DRAIN_CYCLES  = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam int RECENT_DEPTH  = 32;
  localparam int ITEMS_PER_PEN = 150;
  localparam int PEN_SETTINGS  = 6;
  localparam cfg_idx_t CFG_UNMAPPED = cfg_idx_t'(2'd3);

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  logic      cfg_we = 1'b0;
  cfg_idx_t  cfg_index = CFG_PEN_RED;
  logic [COLOR_W-1:0] cfg_data = '0;

  // drawing state as seen from outside
  logic [PIX_W-1:0]   frame_model [PIX_COUNT];
  logic [COLOR_W-1:0] ink_red = 8'hff;
  logic [COLOR_W-1:0] ink_green = 8'hff;
  logic [COLOR_W-1:0] ink_blue = 8'hff;
  logic [11:0]        recent_px_q [$];

  out_item_t expected_readback_q [$];
  int        mismatch_cnt = 0;
  int        cycle_cnt = 0;
  int        burst_left = 0;

  line_rectangle_frame_drawer i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int floor_quot(int num, int den);
    int q;
    q = num / den;
    if ((num % den) != 0 && num < 0) q = q - 1;
    return q;
  endfunction

  function automatic void paint_pixel(int x, int y);
    if (x < 0 || y < 0 || x >= FRAME_WIDTH || y >= FRAME_HEIGHT) return;
    frame_model[y * FRAME_WIDTH + x] = {ink_red, ink_green, ink_blue};
    recent_px_q.push_back({y[5:0], x[5:0]});
    if (recent_px_q.size() > RECENT_DEPTH) void'(recent_px_q.pop_front());
  endfunction

  function automatic void paint_segment(int x1, int y1, int x2, int y2);
    int lo, hi, num, den;
    if (x1 == x2) begin
      lo = (y1 < y2) ? y1 : y2;
      hi = (y1 < y2) ? y2 : y1;
      for (int i = lo; i < hi; i++) paint_pixel(x1, i);
      return;
    end
    lo = (x1 < x2) ? x1 : x2;
    hi = (x1 < x2) ? x2 : x1;
    for (int i = lo; i <= hi; i++) begin
      num = (y2 - y1) * (i - x1);
      den = x2 - x1;
      if (den < 0) begin
        den = -den;
        num = -num;
      end
      paint_pixel(i, y1 + floor_quot(num, den));
    end
  endfunction

  function automatic out_item_t predict_readback(in_item_t c);
    int x1, y1, x2, y2;
    logic [PIX_W-1:0] px;
    x1 = int'(c.start_x);
    y1 = int'(c.start_y);
    x2 = int'(c.end_x);
    y2 = int'(c.end_y);
    px = '0;
    case (c.op)
      OP_PLOT: paint_pixel(x1, y1);
      OP_LINE: paint_segment(x1, y1, x2, y2);
      OP_RECT: begin
        paint_segment(x1, y1, x2, y1);
        paint_segment(x1, y1, x1, y2);
        paint_segment(x2, y1, x2, y2);
        paint_segment(x1, y2, x2, y2);
      end
      default: begin
        if (x1 < FRAME_WIDTH && y1 < FRAME_HEIGHT) px = frame_model[y1 * FRAME_WIDTH + x1];
      end
    endcase
    return out_item_t'(px);
  endfunction

  function automatic in_item_t cmd_of(op_t op, int sx, int sy, int ex, int ey);
    in_item_t c;
    c.op      = op;
    c.start_x = sx[COORD_W-1:0];
    c.start_y = sy[COORD_W-1:0];
    c.end_x   = ex[COORD_W-1:0];
    c.end_y   = ey[COORD_W-1:0];
    return c;
  endfunction

  function automatic logic [COORD_W-1:0] near_coord(logic [COORD_W-1:0] base);
    int v;
    v = int'(base) + int'($urandom_range(12)) - 6;
    if (v < 0) v = 0;
    if (v > 63) v = 63;
    return v[COORD_W-1:0];
  endfunction

  // mostly short shapes near a random anchor; reads favor recently drawn pixels
  function automatic in_item_t random_cmd();
    in_item_t c;
    int pick;
    logic [11:0] spot;
    pick = $urandom_range(99);
    c.start_x = COORD_W'($urandom_range(63));
    c.start_y = COORD_W'($urandom_range(63));
    c.end_x   = COORD_W'($urandom_range(63));
    c.end_y   = COORD_W'($urandom_range(63));
    if (pick < 20) c.op = OP_PLOT;
    else if (pick < 45) c.op = OP_LINE;
    else if (pick < 60) c.op = OP_RECT;
    else c.op = OP_READ;
    if ((c.op == OP_LINE || c.op == OP_RECT) && $urandom_range(9) != 0) begin
      c.end_x = near_coord(c.start_x);
      c.end_y = near_coord(c.start_y);
    end
    if (c.op == OP_LINE && $urandom_range(9) == 0) c.end_x = c.start_x;
    if (c.op == OP_READ && recent_px_q.size() != 0 && $urandom_range(2) != 0) begin
      spot = recent_px_q[$urandom_range(recent_px_q.size() - 1)];
      c.start_x = spot[5:0];
      c.start_y = spot[11:6];
    end
    return c;
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic send_cmd(input in_item_t cmd);
    in_valid <= 1'b1;
    in_data  <= cmd;
    do @(posedge clk); while (!in_ready);
    expected_readback_q.push_back(predict_readback(cmd));
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = $urandom_range(0, 24);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_readback_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_pen(input logic [COLOR_W-1:0] r, g, b);
    cfg_idx_t order [4];
    order = '{CFG_PEN_RED, CFG_PEN_GREEN, CFG_PEN_BLUE, CFG_UNMAPPED};
    wait_idle();
    foreach (order[k]) begin
      cfg_we    <= 1'b1;
      cfg_index <= order[k];
      case (order[k])
        CFG_PEN_RED: begin
          cfg_data <= r;
          ink_red = r;
        end
        CFG_PEN_GREEN: begin
          cfg_data <= g;
          ink_green = g;
        end
        CFG_PEN_BLUE: begin
          cfg_data <= b;
          ink_blue = b;
        end
        default: cfg_data <= COLOR_W'($urandom_range(255));
      endcase
      @(negedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic test_cleared_frame();
    send_cmd(cmd_of(OP_READ, 0, 0, 63, 63));
    send_cmd(cmd_of(OP_READ, 63, 63, 0, 0));
    send_cmd(cmd_of(OP_READ, 17, 42, 21, 10));
  endtask

  task automatic test_plot_and_read();
    send_cmd(cmd_of(OP_PLOT, 0, 0, 63, 63));
    send_cmd(cmd_of(OP_PLOT, 63, 63, 0, 0));
    send_cmd(cmd_of(OP_READ, 0, 0, 0, 0));
    send_cmd(cmd_of(OP_READ, 63, 63, 63, 63));
    set_pen(8'h00, 8'ha5, 8'hff);
    send_cmd(cmd_of(OP_PLOT, 63, 0, 42, 21));
    send_cmd(cmd_of(OP_READ, 63, 0, 0, 63));
  endtask

  task automatic test_lines();
    send_cmd(cmd_of(OP_LINE, 0, 10, 63, 10));
    send_cmd(cmd_of(OP_LINE, 5, 0, 5, 63));
    send_cmd(cmd_of(OP_LINE, 20, 20, 20, 20));
    send_cmd(cmd_of(OP_LINE, 40, 63, 30, 0));
    send_cmd(cmd_of(OP_LINE, 0, 63, 63, 0));
    send_cmd(cmd_of(OP_READ, 63, 10, 0, 0));
    send_cmd(cmd_of(OP_READ, 5, 62, 0, 0));
    send_cmd(cmd_of(OP_READ, 5, 63, 0, 0));
    send_cmd(cmd_of(OP_READ, 20, 20, 0, 0));
    send_cmd(cmd_of(OP_READ, 35, 31, 0, 0));
  endtask

  task automatic test_rectangles();
    set_pen(8'hff, 8'h00, 8'h5a);
    send_cmd(cmd_of(OP_RECT, 10, 30, 50, 60));
    send_cmd(cmd_of(OP_RECT, 60, 5, 45, 25));
    send_cmd(cmd_of(OP_RECT, 33, 33, 33, 33));
    send_cmd(cmd_of(OP_READ, 50, 60, 0, 0));
    send_cmd(cmd_of(OP_READ, 60, 25, 0, 0));
    send_cmd(cmd_of(OP_READ, 45, 5, 0, 0));
    send_cmd(cmd_of(OP_READ, 33, 33, 0, 0));
  endtask

  task automatic test_random_traffic();
    for (int p = 0; p < PEN_SETTINGS; p++) begin
      case (p)
        0:       set_pen(8'h00, 8'h00, 8'h00);
        1:       set_pen(8'hff, 8'hff, 8'hff);
        default: set_pen(COLOR_W'($urandom_range(255)), COLOR_W'($urandom_range(255)),
                         COLOR_W'($urandom_range(255)));
      endcase
      for (int n = 0; n < ITEMS_PER_PEN; n++) send_cmd(random_cmd());
    end
  endtask

  initial begin
    foreach (frame_model[k]) frame_model[k] = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    // clearing pass after reset
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    test_cleared_frame();
    test_plot_and_read();
    test_lines();
    test_rectangles();
    test_random_traffic();
    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_cnt == 0 && expected_readback_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // receiver: free-running stretches, then random stall runs
  always @(negedge clk) begin : rcv_pattern
    int hold;
    bit take;
    if (hold > 0) begin
      hold--;
    end else if (cycle_cnt % 1024 < 256) begin
      out_ready <= 1'b1;
    end else begin
      take = ($urandom_range(1) != 0);
      out_ready <= take;
      hold = take ? $urandom_range(0, 6) : $urandom_range(0, 14);
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > RUN_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin : readback_check
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_readback_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("unexpected result item %h", out_data);
      end else begin
        want = expected_readback_q.pop_front();
        if (out_data.read_red !== want.read_red || out_data.read_green !== want.read_green ||
            out_data.read_blue !== want.read_blue) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("readback mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                     want.read_red, want.read_green, want.read_blue,
                     out_data.read_red, out_data.read_green, out_data.read_blue);
        end
      end
    end
  end

endmodule
